// ===== rtl/power_of_d_choices_dispatcher_top_defines.svh =====
// -----------------------------------------------------------------------------
// Dispatcher assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low; empty for synthesis.
// -----------------------------------------------------------------------------
`ifndef POWER_OF_D_CHOICES_DISPATCHER_TOP_DEFINES_SVH
`define POWER_OF_D_CHOICES_DISPATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, usually written with |->
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition now implies a condition in the next cycle
`define PDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PDC_ASSERT(lbl, prop, msg)
`define PDC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/pdc_pkg.sv =====
// -----------------------------------------------------------------------------
// pdc_pkg
// Shared constants, register indexes and controller/datapath interface types.
// -----------------------------------------------------------------------------
package pdc_pkg;

  // Parameter defaults
  localparam int unsigned MAX_SERVERS_DEF = 64;
  localparam int unsigned MAX_SAMPLES_DEF = 8;
  localparam int unsigned LEN_BITS_DEF    = 16;

  // Fixed port widths
  localparam int unsigned DRAW_W      = 16;
  localparam int unsigned NUM_DRAWS   = 8;
  localparam int unsigned SRV_PORT_W  = 6;
  localparam int unsigned QLEN_PORT_W = 16;
  localparam int unsigned TOTAL_W     = 22;
  localparam int unsigned ACT_W       = 7;
  localparam int unsigned SMP_W       = 4;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SERVERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 1'b1;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;
  localparam logic [SMP_W-1:0] SAMPLE_RESET = 4'd2;

  // Opcodes
  localparam logic OP_ARRIVAL    = 1'b0;
  localparam logic OP_COMPLETION = 1'b1;

  // Modulo unit: bits retired per cycle
  localparam int unsigned MOD_BITS_PER_STEP = 4;
  localparam int unsigned MOD_STEPS         = DRAW_W / MOD_BITS_PER_STEP;
  localparam int unsigned MOD_CNT_W         = $clog2(MOD_STEPS);

  typedef struct packed {
    logic start;     // capture input word, set up draw loop
    logic clr_step;  // write one zero in the clearing sweep
    logic mod_load;  // load next draw into the modulo unit
    logic mod_step;  // retire MOD_BITS_PER_STEP dividend bits
    logic look;      // permutation lookup/swap, issue length read
    logic cmpr;      // compare sampled length against best
    logic fin;       // commit queue update, load output register
  } pdc_cmd_t;

  typedef struct packed {
    logic opcode;
    logic clr_last;
    logic mod_last;
    logic draw_last;
    logic out_busy;
  } pdc_sts_t;

endpackage

// ===== rtl/pdc_ram.sv =====
// -----------------------------------------------------------------------------
// pdc_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module pdc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/pdc_ctrl.sv =====
// -----------------------------------------------------------------------------
// pdc_ctrl
// Sequencer: clearing sweep, draw loop (load, modulo, lookup, compare), commit.
// -----------------------------------------------------------------------------
module pdc_ctrl import pdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output pdc_cmd_t cmd_o,
  input  pdc_sts_t sts_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_CMPR  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        // completion: length read of the named queue is in flight
        if (sts_i.opcode == OP_COMPLETION) begin
          state_d = S_FIN;
        end else begin
          cmd_o.mod_load = 1'b1;
          state_d        = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_CMPR;
      end
      S_CMPR: begin
        cmd_o.cmpr = 1'b1;
        state_d    = sts_i.draw_last ? S_FIN : S_LOAD;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pdc_dp.sv =====
// -----------------------------------------------------------------------------
// pdc_dp
// Datapath: config registers, modulo unit, swap table, length RAM, output word.
// -----------------------------------------------------------------------------
module pdc_dp import pdc_pkg::*; #(
  parameter int unsigned MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned LEN_BITS    = LEN_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pdc_cmd_t               cmd_i,
  output pdc_sts_t               sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   opcode_i,
  input  logic [SRV_PORT_W-1:0]  server_index_i,
  input  logic [DRAW_W-1:0]      draws_i [NUM_DRAWS],
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [SRV_PORT_W-1:0]  chosen_server_o,
  output logic [QLEN_PORT_W-1:0] queue_length_o,
  output logic                   starts_service_o,
  output logic                   ignored_o,
  output logic                   overflow_o,
  output logic [TOTAL_W-1:0]     total_in_system_o
);

  localparam int unsigned SRV_W = $clog2(MAX_SERVERS);
  localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int unsigned IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [LEN_BITS-1:0] LEN_MAX   = {LEN_BITS{1'b1}};
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX = {TOTAL_W{1'b1}};

  // config
  logic [ACT_W-1:0] cfg_act_q;
  logic [SMP_W-1:0] cfg_smp_q;
  logic [CNT_W-1:0] n_eff;
  logic [SMP_W-1:0] d_eff;

  // item state
  logic                  opcode_q;
  logic [SRV_PORT_W-1:0] idx_q;
  logic [DRAW_W-1:0]     draw_q [MAX_SAMPLES];
  logic [CNT_W-1:0]      rem_q;
  logic [SMP_W-1:0]      d_q;
  logic [IDX_W-1:0]      i_q;
  logic [DRAW_W-1:0]     dvd_q, dvd_d;
  logic [CNT_W-1:0]      rmd_q, rmd_d;
  logic [MOD_CNT_W-1:0]  mod_cnt_q;
  logic [SRV_W-1:0]      ov_pos_q [MAX_SAMPLES];
  logic [SRV_W-1:0]      ov_val_q [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] ov_vld_q;
  logic [SRV_W-1:0]      srv_q, best_q;
  logic [LEN_BITS-1:0]   best_len_q;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [SRV_W-1:0]      clr_q;
  logic                  out_valid_q;

  // lookup
  logic [SRV_W-1:0] slot, tail_pos, srv_look, tail_val;
  logic [CNT_W-1:0] rem_m1;

  // RAM
  logic                ram_we;
  logic [SRV_W-1:0]    ram_waddr, ram_raddr;
  logic [LEN_BITS-1:0] ram_wdata, ram_rdata;

  // commit
  logic [31:0]           idx_ext, best_ext, len_ext;
  logic [SRV_W-1:0]      idx_addr;
  logic                  idx_in_range;
  logic                  arr_sat, cmp_ok;
  logic [LEN_BITS-1:0]   rd_dec, fin_len;
  logic                  fin_we, fin_starts, fin_ign, fin_ovf;
  logic [SRV_W-1:0]      fin_srv;
  logic [SRV_PORT_W-1:0] fin_chosen;

  // ---------------------------------------------------------------------------
  // Effective N and d
  // ---------------------------------------------------------------------------
  always_comb begin
    int unsigned act_v, smp_v, n_v, d_v;
    act_v = 32'(cfg_act_q);
    smp_v = 32'(cfg_smp_q);
    if (act_v < 1) n_v = 1;
    else if (act_v > MAX_SERVERS) n_v = MAX_SERVERS;
    else n_v = act_v;
    if (smp_v < 1) d_v = 1;
    else if (smp_v > MAX_SAMPLES) d_v = MAX_SAMPLES;
    else d_v = smp_v;
    if (d_v > n_v) d_v = n_v;
    n_eff = CNT_W'(n_v);
    d_eff = SMP_W'(d_v);
  end

  // ---------------------------------------------------------------------------
  // Modulo unit: restoring, MOD_BITS_PER_STEP quotient bits per cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [CNT_W:0] t;
    logic [CNT_W-1:0] r;
    logic [DRAW_W-1:0] dv;
    r  = rmd_q;
    dv = dvd_q;
    for (int k = 0; k < MOD_BITS_PER_STEP; k++) begin
      t  = {r, dv[DRAW_W-1]};
      dv = dv << 1;
      if (t >= {1'b0, rem_q}) t = t - {1'b0, rem_q};
      r = t[CNT_W-1:0];
    end
    rmd_d = r;
    dvd_d = dv;
  end

  // ---------------------------------------------------------------------------
  // Partial shuffle: identity permutation plus at most one swap per draw.
  // Later entries override earlier ones at the same position.
  // ---------------------------------------------------------------------------
  assign rem_m1   = rem_q - CNT_W'(1);
  assign slot     = rmd_q[SRV_W-1:0];
  assign tail_pos = rem_m1[SRV_W-1:0];

  always_comb begin
    srv_look = slot;
    tail_val = tail_pos;
    for (int j = 0; j < MAX_SAMPLES; j++) begin
      if (ov_vld_q[j] && ov_pos_q[j] == slot)     srv_look = ov_val_q[j];
      if (ov_vld_q[j] && ov_pos_q[j] == tail_pos) tail_val = ov_val_q[j];
    end
  end

  // ---------------------------------------------------------------------------
  // Commit logic
  // ---------------------------------------------------------------------------
  assign idx_ext      = 32'(idx_q);
  assign idx_addr     = idx_ext[SRV_W-1:0];
  assign idx_in_range = (idx_ext < MAX_SERVERS);
  assign best_ext     = 32'(best_q);

  always_comb begin
    arr_sat = (best_len_q == LEN_MAX);
    cmp_ok  = idx_in_range && (ram_rdata != '0);
    rd_dec  = ram_rdata - LEN_BITS'(1);
    total_d = total_q;
    if (opcode_q == OP_COMPLETION) begin
      fin_we     = cmp_ok;
      fin_srv    = idx_addr;
      fin_len    = cmp_ok ? rd_dec : '0;
      fin_starts = cmp_ok && (rd_dec != '0);
      fin_ign    = !cmp_ok;
      fin_ovf    = 1'b0;
      fin_chosen = idx_q;
      if (cmp_ok && total_q != '0) total_d = total_q - TOTAL_W'(1);
    end else begin
      fin_we     = !arr_sat;
      fin_srv    = best_q;
      fin_len    = arr_sat ? best_len_q : best_len_q + LEN_BITS'(1);
      fin_starts = !arr_sat && (best_len_q == '0);
      fin_ign    = 1'b0;
      fin_ovf    = arr_sat;
      fin_chosen = best_ext[SRV_PORT_W-1:0];
      if (!arr_sat && total_q != TOTAL_MAX) total_d = total_q + TOTAL_W'(1);
    end
  end

  assign len_ext = 32'(fin_len);

  // ---------------------------------------------------------------------------
  // Length RAM
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fin_srv;
    ram_wdata = fin_len;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.fin) begin
      ram_we = fin_we;
    end
  end

  assign ram_raddr = cmd_i.look ? srv_look : idx_addr;

  pdc_ram #(
    .WIDTH (LEN_BITS),
    .DEPTH (MAX_SERVERS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_act_q   <= ACTIVE_RESET;
      cfg_smp_q   <= SAMPLE_RESET;
      total_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      ov_vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ACTIVE_SERVERS: cfg_act_q <= cfg_data_i[ACT_W-1:0];
          CFG_SAMPLE_COUNT:   cfg_smp_q <= cfg_data_i[SMP_W-1:0];
        endcase
      end
      if (cmd_i.clr_step) clr_q <= clr_q + SRV_W'(1);
      if (cmd_i.start) ov_vld_q <= '0;
      else if (cmd_i.look) ov_vld_q[i_q] <= 1'b1;
      if (cmd_i.fin) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      opcode_q <= opcode_i;
      idx_q    <= server_index_i;
      for (int k = 0; k < MAX_SAMPLES; k++) draw_q[k] <= draws_i[k];
      rem_q    <= n_eff;
      d_q      <= d_eff;
      i_q      <= '0;
    end
    if (cmd_i.mod_load) begin
      dvd_q     <= draw_q[i_q];
      rmd_q     <= '0;
      mod_cnt_q <= '0;
    end
    if (cmd_i.mod_step) begin
      dvd_q     <= dvd_d;
      rmd_q     <= rmd_d;
      mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
    end
    if (cmd_i.look) begin
      ov_pos_q[i_q] <= slot;
      ov_val_q[i_q] <= tail_val;
      srv_q         <= srv_look;
      rem_q         <= rem_m1;
    end
    if (cmd_i.cmpr) begin
      if (i_q == '0 || ram_rdata < best_len_q) begin
        best_q     <= srv_q;
        best_len_q <= ram_rdata;
      end
      i_q <= i_q + IDX_W'(1);
    end
    if (cmd_i.fin) begin
      chosen_server_o  <= fin_chosen;
      queue_length_o   <= len_ext[QLEN_PORT_W-1:0];
      starts_service_o <= fin_starts;
      ignored_o        <= fin_ign;
      overflow_o       <= fin_ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign total_in_system_o = total_q;

  assign sts_o.opcode    = opcode_q;
  assign sts_o.clr_last  = (clr_q == SRV_W'(MAX_SERVERS - 1));
  assign sts_o.mod_last  = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign sts_o.draw_last = ((32'(i_q) + 32'd1) == 32'(d_q));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// ===== rtl/power_of_d_choices_dispatcher_top.sv =====
// Arrival: d draw loops, then commit; in_stall_o stays high until the commit.
//   Each draw: load, 4 modulo steps (4 bits a step), swap lookup, compare.
// Completion: length read, then commit; no new item is accepted before the commit.
// A waiting output word holds only the commit; the next word is accepted meanwhile.
// Reset: async active low; then a RAM clearing sweep over all MAX_SERVERS entries with in_stall_o high.
// -----------------------------------------------------------------------------
// power_of_d_choices_dispatcher_top
// Join-shortest-of-d dispatcher: per-server queue lengths in a RAM, d distinct
// servers sampled by partial Fisher-Yates shuffle, shortest one takes arrival.
// -----------------------------------------------------------------------------
`include "power_of_d_choices_dispatcher_top_defines.svh"

module power_of_d_choices_dispatcher_top import pdc_pkg::*; #(
  parameter int unsigned MAX_SERVERS = MAX_SERVERS_DEF,  // queue count, 2..64
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,  // max d, 1..8
  parameter int unsigned LEN_BITS    = LEN_BITS_DEF      // length counter width, 4..32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input word
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic [SRV_PORT_W-1:0]  server_index_i,
  input  logic [DRAW_W-1:0]      draw_0_i,
  input  logic [DRAW_W-1:0]      draw_1_i,
  input  logic [DRAW_W-1:0]      draw_2_i,
  input  logic [DRAW_W-1:0]      draw_3_i,
  input  logic [DRAW_W-1:0]      draw_4_i,
  input  logic [DRAW_W-1:0]      draw_5_i,
  input  logic [DRAW_W-1:0]      draw_6_i,
  input  logic [DRAW_W-1:0]      draw_7_i,
  // result word
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SRV_PORT_W-1:0]  chosen_server_o,
  output logic [QLEN_PORT_W-1:0] queue_length_o,
  output logic                   starts_service_o,
  output logic                   ignored_o,
  output logic                   overflow_o,
  output logic [TOTAL_W-1:0]     total_in_system_o
);

  pdc_cmd_t        dp_cmd;
  pdc_sts_t        dp_sts;
  logic [DRAW_W-1:0] draws [NUM_DRAWS];

  // Draw fields gathered into one array; the datapath uses the first MAX_SAMPLES.
  assign draws[0] = draw_0_i;
  assign draws[1] = draw_1_i;
  assign draws[2] = draw_2_i;
  assign draws[3] = draw_3_i;
  assign draws[4] = draw_4_i;
  assign draws[5] = draw_5_i;
  assign draws[6] = draw_6_i;
  assign draws[7] = draw_7_i;

  // Sequencer: owns the input handshake and steps the datapath.
  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

  // Datapath: config, modulo unit, swap table, length RAM, output register.
  pdc_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .LEN_BITS    (LEN_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .server_index_i    (server_index_i),
    .draws_i           (draws),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .chosen_server_o   (chosen_server_o),
    .queue_length_o    (queue_length_o),
    .starts_service_o  (starts_service_o),
    .ignored_o         (ignored_o),
    .overflow_o        (overflow_o),
    .total_in_system_o (total_in_system_o)
  );

  // A word must never be committed over a result that is still stalled.
  `PDC_ASSERT(a_fin_out_free, dp_cmd.fin |-> !dp_sts.out_busy, "commit over stalled result")

  // One word in flight: an accepted word stalls the input on the next cycle.
  `PDC_ASSERT_NEXT(a_single_item, in_valid_i && !in_stall_o, in_stall_o, "second word accepted")

  // An ignored completion neither starts service nor flags overflow.
  `PDC_ASSERT(a_ignored_flags, out_valid_o && ignored_o |-> !starts_service_o && !overflow_o, "ignored word with flags")

endmodule
